// ----- design/sofc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sofc_pkg;

  localparam int unsigned PatMax    = 16;
  localparam int unsigned PatBytes  = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned CntW      = 16;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd2;

  typedef enum logic {
    KindMatch   = 1'b0,
    KindSummary = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e    kind;
    logic [CntW-1:0] start;
    logic [CntW-1:0] total;
    logic            last;
  } result_t;

  function automatic logic [7:0] pat_byte(input logic [PatBytes*8-1:0] pat,
                                          input logic [$clog2(PatBytes)-1:0] idx);
    pat_byte = pat[idx*8 +: 8];
  endfunction

endpackage

`default_nettype wire

// ----- design/sofc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sofc_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic       clear_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] pat_byte_i,
  input  wire logic       active_i,
  output logic      [7:0] byte_o,
  output logic            hit_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare against the byte that lands here on this shift
  assign hit_o  = !active_i || (byte_i == pat_byte_i);
  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- design/sofc_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sofc_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push0_i,
  input  wire logic             push1_i,
  input  wire sofc_pkg::result_t data0_i,
  input  wire sofc_pkg::result_t data1_i,
  output logic                  space_o,
  output logic                  valid_o,
  output sofc_pkg::result_t     data_o,
  input  wire logic             pop_i
);

  sofc_pkg::result_t mem_q [sofc_pkg::FifoDepth];

  logic [sofc_pkg::PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d, wptr_p1;
  logic [sofc_pkg::FillW-1:0] fill_q, fill_d;
  logic                       pop;

  assign pop     = pop_i && valid_o;
  assign wptr_p1 = wptr_q + sofc_pkg::PtrW'(1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push0_i && push1_i) begin
      wptr_d = wptr_q + sofc_pkg::PtrW'(2);
      fill_d = fill_d + sofc_pkg::FillW'(2);
    end else if (push0_i) begin
      wptr_d = wptr_p1;
      fill_d = fill_d + sofc_pkg::FillW'(1);
    end
    if (pop) begin
      rptr_d = rptr_q + sofc_pkg::PtrW'(1);
      fill_d = fill_d - sofc_pkg::FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push0_i && push1_i) begin
      mem_q[wptr_p1] <= data1_i;
    end
  end

  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rptr_q];
  // one input can cause two results
  assign space_o = (fill_q <= sofc_pkg::FillW'(sofc_pkg::FifoDepth - 2));

endmodule

`default_nettype wire

// ----- design/substring_occurrence_finder_core.sv -----
// Each result is written to the result queue on its input transfer and is read out on the m_ side.
// Throughput: one text byte per cycle while each byte causes at most one result and m_tready_i is high;
// a byte that causes a match and a summary delivers them one after the other.
// The 4-entry result queue has a write port pair and one read per cycle.
// Reset: rst_ni async active low clears window, position, count, pattern registers
// and the result queue; the block is ready for input as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module substring_occurrence_finder_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid_i,
  output logic                                s_tready_o,
  input  wire logic [7:0]                     s_tdata_i,  // [7:0] text_byte
  input  wire logic                           s_tlast_i,  // end_of_text
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic [31:0]                         m_tdata_o,  // [15:0] start_position, [31:16] match_total
  output logic                                m_tlast_o,  // high on summary, match not at end_of_text
  output logic                                m_tuser_o,  // result_kind
  input  wire logic                           cfg_we_i,
  input  wire logic [sofc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sofc_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned PatMax = sofc_pkg::PatMax;
  localparam int unsigned LenW   = sofc_pkg::LenW;
  localparam int unsigned CntW   = sofc_pkg::CntW;

  // configuration
  logic [sofc_pkg::PatBytes*8-1:0] pat_q;
  logic [LenW-1:0]                 len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sofc_pkg::CfgPatLow:  pat_q[63:0]   <= cfg_data_i;
        sofc_pkg::CfgPatHigh: pat_q[127:64] <= cfg_data_i;
        sofc_pkg::CfgPatLen:  len_q         <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  logic [LenW-1:0] len_eff;
  assign len_eff = (len_q > LenW'(PatMax)) ? LenW'(PatMax) : len_q;

  // window chain
  logic             acc, fifo_space;
  logic [7:0]       win   [PatMax];
  logic [7:0]       chin  [PatMax];
  logic [PatMax-1:0] cell_hit;

  assign acc = s_tvalid_i && s_tready_o;

  for (genvar j = 0; j < PatMax; j++) begin : g_cell
    logic [LenW-1:0] pidx;
    logic            act;

    assign pidx = len_eff - LenW'(j) - LenW'(1);
    assign act  = (LenW'(j) < len_eff);

    if (j == 0) begin : g_head
      assign chin[j] = s_tdata_i;
    end else begin : g_body
      assign chin[j] = win[j-1];
    end

    sofc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (acc),
      .clear_i    (acc && s_tlast_i),
      .byte_i     (chin[j]),
      .pat_byte_i (sofc_pkg::pat_byte(pat_q, pidx[$clog2(sofc_pkg::PatBytes)-1:0])),
      .active_i   (act),
      .byte_o     (win[j]),
      .hit_o      (cell_hit[j])
    );
  end

  // position and count
  logic [CntW-1:0] pos_q, pos_d, pos_nxt, cnt_q, cnt_d, cnt_nxt, start;
  logic [LenW-1:0] len_m1;
  logic            hit;

  assign pos_nxt = (pos_q == '1) ? pos_q : pos_q + CntW'(1);
  assign hit     = (&cell_hit) && (pos_nxt >= CntW'(len_eff));
  assign cnt_nxt = (hit && cnt_q != '1) ? cnt_q + CntW'(1) : cnt_q;
  assign len_m1  = (len_eff == '0) ? '0 : len_eff - LenW'(1);
  assign start   = pos_nxt - CntW'(len_m1);

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (acc) begin
      pos_d = s_tlast_i ? '0 : pos_nxt;
      cnt_d = s_tlast_i ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  // result queue
  sofc_pkg::result_t r_match, r_sum, r_out;

  always_comb begin
    r_match.kind  = sofc_pkg::KindMatch;
    r_match.start = start;
    r_match.total = cnt_nxt;
    r_match.last  = !s_tlast_i;
    r_sum.kind    = sofc_pkg::KindSummary;
    r_sum.start   = '0;
    r_sum.total   = cnt_nxt;
    r_sum.last    = 1'b1;
  end

  sofc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (acc && (hit || s_tlast_i)),
    .push1_i (acc && hit && s_tlast_i),
    .data0_i (hit ? r_match : r_sum),
    .data1_i (r_sum),
    .space_o (fifo_space),
    .valid_o (m_tvalid_o),
    .data_o  (r_out),
    .pop_i   (m_tready_i)
  );

  assign s_tready_o = fifo_space;
  assign m_tdata_o  = {r_out.total, r_out.start};
  assign m_tlast_o  = r_out.last;
  assign m_tuser_o  = r_out.kind;

endmodule

`default_nettype wire

// ----- design/sofc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sofc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [31:0] m_tdata_o,
  input wire logic        m_tlast_o,
  input wire logic        m_tuser_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  a_sum_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == sofc_pkg::KindSummary |->
      m_tlast_o && m_tdata_o[15:0] == 16'd0)
    else $error("malformed summary");

  a_match_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o == sofc_pkg::KindMatch |->
      m_tdata_o[15:0] != 16'd0 && m_tdata_o[31:16] != 16'd0)
    else $error("match with zero position or count");

  a_match_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && m_tuser_o == sofc_pkg::KindMatch && !m_tlast_o |=>
      m_tvalid_o && m_tuser_o == sofc_pkg::KindSummary)
    else $error("match on last byte not followed by summary");

endmodule

bind substring_occurrence_finder_core sofc_checker u_sofc_checker (.*);

`default_nettype wire
